>>> rtl/wrol_pkg.sv
// Package for the write record ring with offset lookup.
// Holds the beat payload types, function codes, cell ops and controller states.
// No dependencies.
package wrol_pkg;

    // Function codes of a request beat
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 16;
    localparam int OFFSET_W = 20;

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] entry_handle;
        logic [LENGTH_W-1:0] entry_length;
        logic [OFFSET_W-1:0] byte_offset;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] hit_handle;
        logic [LENGTH_W-1:0] hit_length;
        logic [LENGTH_W-1:0] byte_in_record;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } t_rsp;

    // One stored record as held in a cell
    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } t_record;

    // What a cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE,
        CELL_LOAD
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

>>> rtl/wrol_chan_if.sv
// Request and response channels of the record ring.
// Depends on wrol_pkg for the payload types.
interface wrol_req_if import wrol_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wrol_rsp_if import wrol_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/wrol_cell.sv
// One cell of the record chain: holds a record, takes its neighbor's or a new one.
// Depends on wrol_pkg.
module wrol_cell import wrol_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_op i_op,
    input  t_record  i_nb,
    input  t_record  i_new,
    output t_record  o_rec
);

    logic                r_valid;
    logic [HANDLE_W-1:0] r_handle;
    logic [LENGTH_W-1:0] r_length;

    // Valid bit: cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                CELL_TAKE: r_valid <= i_nb.valid;
                CELL_LOAD: r_valid <= i_new.valid;
                default:   r_valid <= r_valid;
            endcase
        end
    end

    // Record payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_TAKE: begin
                r_handle <= i_nb.handle;
                r_length <= i_nb.length;
            end
            CELL_LOAD: begin
                r_handle <= i_new.handle;
                r_length <= i_new.length;
            end
            default: begin
                r_handle <= r_handle;
                r_length <= r_length;
            end
        endcase
    end

    assign o_rec.valid  = r_valid;
    assign o_rec.handle = r_handle;
    assign o_rec.length = r_length;

endmodule

>>> rtl/write_record_ring_offset_lookup.sv
// Top level: ring of write records kept as a chain of cells, oldest in cell 0.
// Depends on wrol_pkg, wrol_chan_if and wrol_cell.
//
//  channel  | dir | payload                                             | beat
//  i_req    | in  | func, entry_handle, entry_length, byte_offset       | valid & ready
//  o_rsp    | out | found, hit/len/byte_in_record, evicted, ev. handle  | valid & ready
//
// An add passes from its request beat through ST_DONE into the response register; a find
// first walks ST_WALK, the chain rotating once past cell 0, one cell a cycle, then ST_DONE.
// The next request is taken back in ST_IDLE. One item is in work at a time; the next
// is taken while a response still waits in the output register, and a finished item
// holds while that register is full.
// Synchronous reset empties the chain at once.
module write_record_ring_offset_lookup import wrol_pkg::*; #(
    parameter int RING_ENTRIES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrol_req_if.sink    i_req,
    wrol_rsp_if.source  o_rsp
);

    localparam int CNT_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int SUM_W = LENGTH_W + $clog2(RING_ENTRIES + 1);
    localparam int CMP_W = (SUM_W > OFFSET_W) ? SUM_W : OFFSET_W;

    t_state           r_state, n_state;
    logic [CMP_W-1:0] r_sum, n_sum;
    logic [CMP_W-1:0] r_off, n_off;
    logic [CNT_W-1:0] r_step, n_step;
    t_rsp             r_res, n_res;
    t_rsp             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    t_record          w_rec [RING_ENTRIES];
    t_cell_op         w_op  [RING_ENTRIES];
    t_record          w_new;
    logic             w_accept;
    logic             w_add;
    logic             w_full;
    logic [CMP_W-1:0] w_add_sum;
    logic [CMP_W-1:0] w_rel;

    assign w_accept  = i_req.valid & i_req.ready;
    assign w_add     = w_accept & (i_req.data.func == FUNC_ADD);
    assign w_full    = w_rec[RING_ENTRIES-1].valid;
    assign w_add_sum = r_sum + CMP_W'(w_rec[0].length);
    assign w_rel     = r_off - r_sum;

    assign w_new.valid  = 1'b1;
    assign w_new.handle = i_req.data.entry_handle;
    assign w_new.length = i_req.data.entry_length;

    // Cell chain: each cell takes from its upper neighbor, the last one from cell 0
    for (genvar g = 0; g < RING_ENTRIES; g++) begin : g_cell
        localparam int NB = (g == RING_ENTRIES - 1) ? 0 : g + 1;

        logic w_prev_valid;
        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_rec[g-1].valid;
        end

        // Pick the cell op: append, shift out the oldest, or rotate for a walk
        always_comb begin
            if (w_add) begin
                if (w_full) begin
                    w_op[g] = (g == RING_ENTRIES - 1) ? CELL_LOAD : CELL_TAKE;
                end else begin
                    w_op[g] = (!w_rec[g].valid && w_prev_valid) ? CELL_LOAD : CELL_HOLD;
                end
            end else if (r_state == ST_WALK) begin
                w_op[g] = CELL_TAKE;
            end else begin
                w_op[g] = CELL_HOLD;
            end
        end

        wrol_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[g]),
            .i_nb    (w_rec[NB]),
            .i_new   (w_new),
            .o_rec   (w_rec[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.data.func == FUNC_ADD) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_step == CNT_W'(RING_ENTRIES - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_sum       = r_sum;
        n_off       = r_off;
        n_step      = r_step;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res  = '0;
                    n_sum  = '0;
                    n_step = '0;
                    n_off  = CMP_W'(i_req.data.byte_offset);
                    if (i_req.data.func == FUNC_ADD && w_full) begin
                        n_res.evicted        = 1'b1;
                        n_res.evicted_handle = w_rec[0].handle;
                    end
                end
            end
            ST_WALK: begin
                n_step = r_step + 1'b1;
                // Accumulate the head record while nothing has matched yet
                if (w_rec[0].valid && !r_res.found) begin
                    n_sum = w_add_sum;
                    if (r_off < w_add_sum) begin
                        n_res.found          = 1'b1;
                        n_res.hit_handle     = w_rec[0].handle;
                        n_res.hit_length     = w_rec[0].length;
                        n_res.byte_in_record = w_rel[LENGTH_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        // Drop a taken beat, then load a finished result when the slot is free
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == ST_DONE && (!r_out_valid || o_rsp.ready)) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end
    end

    // Handshake outputs
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        o_rsp.valid = r_out_valid;
        o_rsp.data  = r_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_off  <= n_off;
        r_step <= n_step;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

>>> tb/sv/write_record_ring_offset_lookup_tb.sv
// Testbench for the write record ring with offset lookup: directed table, then random beats.
// Responses are checked field by field against the directed table's expected values or an in-bench model of the ring.
// Depends on wrol_pkg, wrol_chan_if and write_record_ring_offset_lookup.
module write_record_ring_offset_lookup_tb;
    import wrol_pkg::*;

    localparam int RING_ENTRIES   = 10;
    localparam int CLK_PERIOD     = 8;
    localparam int ITEMS_PER_PASS = 640;
    localparam int HOLD_CYCLES    = 96;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wrol_req_if req_if ();
    wrol_rsp_if rsp_if ();

    write_record_ring_offset_lookup #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the ring, advanced at every accepted request beat
    logic [HANDLE_W-1:0] slot_handle [RING_ENTRIES] = '{default: '0};
    logic [LENGTH_W-1:0] slot_length [RING_ENTRIES] = '{default: '0};
    int unsigned         wr_slot     = 0;
    int unsigned         rd_slot     = 0;
    bit                  ring_full_q = 1'b0;

    t_rsp        due_rsp_q [$];
    int unsigned mismatches    = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned snk_idle_pct  = 0;
    bit          stall_request = 1'b0;

    function automatic int unsigned records_held();
        if (ring_full_q) return RING_ENTRIES;
        if (wr_slot >= rd_slot) return wr_slot - rd_slot;
        return RING_ENTRIES - rd_slot + wr_slot;
    endfunction

    // Apply one request to the shadow ring and return the response it causes
    function automatic t_rsp ring_apply(input t_req r);
        t_rsp        rsp;
        int unsigned n;
        int unsigned idx;
        int unsigned sum;
        rsp = '0;
        if (r.func == FUNC_ADD) begin
            if (ring_full_q) begin
                rsp.evicted        = 1'b1;
                rsp.evicted_handle = slot_handle[wr_slot];
            end
            slot_handle[wr_slot] = r.entry_handle;
            slot_length[wr_slot] = r.entry_length;
            wr_slot = (wr_slot + 1) % RING_ENTRIES;
            if (ring_full_q) rd_slot = wr_slot;
            else ring_full_q = (wr_slot == rd_slot);
        end else begin
            n   = records_held();
            idx = rd_slot;
            sum = 0;
            // Walk oldest first; a zero-length record can never hold the offset
            for (int i = 0; i < n; i++) begin
                sum += slot_length[idx];
                if (r.byte_offset < sum) begin
                    rsp.found          = 1'b1;
                    rsp.hit_handle     = slot_handle[idx];
                    rsp.hit_length     = slot_length[idx];
                    rsp.byte_in_record = LENGTH_W'(r.byte_offset - (sum - slot_length[idx]));
                    break;
                end
                idx = (idx + 1) % RING_ENTRIES;
            end
        end
        return rsp;
    endfunction

    // Random beat: adds with biased lengths, finds aimed mostly at stored bytes
    function automatic t_req next_ring_item();
        t_req        r;
        int unsigned n;
        int unsigned pick;
        int unsigned idx;
        int unsigned upto;
        int unsigned total;
        r.entry_handle = $urandom();
        r.entry_length = LENGTH_W'($urandom());
        r.byte_offset  = OFFSET_W'($urandom());
        r.func         = ($urandom_range(99) < 50) ? FUNC_ADD : FUNC_FIND;
        if (r.func == FUNC_ADD) begin
            pick = $urandom_range(9);
            if (pick == 0) r.entry_length = '0;
            else if (pick == 1) r.entry_length = '1;
            else if (pick < 6) r.entry_length = LENGTH_W'($urandom_range(1, 64));
        end else begin
            n     = records_held();
            pick  = $urandom_range(n);
            idx   = rd_slot;
            upto  = 0;
            total = 0;
            for (int i = 0; i < n; i++) begin
                if (i < pick) upto += slot_length[idx];
                total += slot_length[idx];
                idx = (idx + 1) % RING_ENTRIES;
            end
            case ($urandom_range(9))
                0, 1, 2:    r.byte_offset = OFFSET_W'(upto + $urandom_range(2) - 1);
                3, 4, 5, 6: r.byte_offset = OFFSET_W'($urandom_range(total));
                7:          r.byte_offset = OFFSET_W'(total + $urandom_range(3));
                default:    ;
            endcase
        end
        return r;
    endfunction

    function automatic t_req mk_add(input logic [HANDLE_W-1:0] h, input logic [LENGTH_W-1:0] l);
        t_req r;
        r              = '0;
        r.func         = FUNC_ADD;
        r.entry_handle = h;
        r.entry_length = l;
        return r;
    endfunction

    function automatic t_req mk_find(input logic [OFFSET_W-1:0] off);
        t_req r;
        r             = '0;
        r.func        = FUNC_FIND;
        r.byte_offset = off;
        return r;
    endfunction

    function automatic t_rsp hit(input logic [HANDLE_W-1:0] h, input logic [LENGTH_W-1:0] l,
                                 input logic [LENGTH_W-1:0] b);
        t_rsp rsp;
        rsp                = '0;
        rsp.found          = 1'b1;
        rsp.hit_handle     = h;
        rsp.hit_length     = l;
        rsp.byte_in_record = b;
        return rsp;
    endfunction

    function automatic t_rsp evict(input logic [HANDLE_W-1:0] h);
        t_rsp rsp;
        rsp                = '0;
        rsp.evicted        = 1'b1;
        rsp.evicted_handle = h;
        return rsp;
    endfunction

    // Offer one request beat, idling at random first; record what it must return
    task automatic push_beat(input t_req r, input bit typed, input t_rsp want);
        t_rsp predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = ring_apply(r);
        due_rsp_q.push_back(typed ? want : predicted);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Drain responses with random back-pressure and an occasional long hold
    initial begin : rsp_drain
        t_rsp        want;
        t_rsp        got;
        int unsigned stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_request) begin
                stall_left    = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            rsp_if.ready <= (stall_left == 0) && ($urandom_range(99) >= snk_idle_pct);
            @(posedge i_clk);
            if (stall_left != 0) stall_left--;
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (due_rsp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: response beat with none expected, got %h", $time, got);
                end else begin
                    want = due_rsp_q.pop_front();
                    check_field("found", 32'(want.found), 32'(got.found));
                    check_field("hit_handle", want.hit_handle, got.hit_handle);
                    check_field("hit_length", 32'(want.hit_length), 32'(got.hit_length));
                    check_field("byte_in_record", 32'(want.byte_in_record),
                                32'(got.byte_in_record));
                    check_field("evicted", 32'(want.evicted), 32'(got.evicted));
                    check_field("evicted_handle", want.evicted_handle, got.evicted_handle);
                end
            end
        end
    end

    // Main sequence: reset, directed table, three random passes, settle
    initial begin : stim_main
        t_dir_row rows [$];
        t_rsp     nothing;
        nothing      = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty ring, extremes, zero-length record, fill, then two evictions
        rows.push_back('{mk_find(20'h00000), 1'b1, nothing});
        rows.push_back('{mk_find(20'hFFFFF), 1'b1, nothing});
        rows.push_back('{mk_add(32'hFFFF_FFFF, 16'hFFFF), 1'b1, nothing});
        rows.push_back('{mk_add(32'h0000_0000, 16'h0000), 1'b1, nothing});
        rows.push_back('{mk_find(20'h00000), 1'b1, hit(32'hFFFF_FFFF, 16'hFFFF, 16'h0000)});
        rows.push_back('{mk_find(20'h0FFFE), 1'b1, hit(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE)});
        rows.push_back('{mk_find(20'h0FFFF), 1'b1, nothing});
        rows.push_back('{mk_add(32'hA5A5_A5A5, 16'h0001), 1'b1, nothing});
        rows.push_back('{mk_find(20'h0FFFF), 1'b1, hit(32'hA5A5_A5A5, 16'h0001, 16'h0000)});
        rows.push_back('{mk_find(20'h10000), 1'b1, nothing});
        for (int k = 0; k < 7; k++) begin
            rows.push_back('{mk_add(32'h1000_0000 + k, 16'(3 * k)), 1'b0, nothing});
        end
        rows.push_back('{mk_add(32'hC0DE_0001, 16'hFFFF), 1'b1, evict(32'hFFFF_FFFF)});
        rows.push_back('{mk_add(32'h5A5A_5A5A, 16'h0007), 1'b1, evict(32'h0000_0000)});
        rows.push_back('{mk_find(20'h00000), 1'b1, hit(32'hA5A5_A5A5, 16'h0001, 16'h0000)});
        rows.push_back('{mk_find(20'h00040), 1'b0, nothing});
        rows.push_back('{mk_find(20'h1003F), 1'b0, nothing});
        rows.push_back('{mk_find(20'hFFFFF), 1'b1, nothing});

        src_idle_pct = 21;
        snk_idle_pct = 62;
        foreach (rows[i]) push_beat(rows[i].req, rows[i].typed, rows[i].want);

        // Random passes: sender-light, receiver-light, then back to back
        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    src_idle_pct = 21;
                    snk_idle_pct = 62;
                end
                1: begin
                    src_idle_pct = 62;
                    snk_idle_pct = 21;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PASS; k++) begin
                if (k == ITEMS_PER_PASS / 3) stall_request = 1'b1;
                push_beat(next_ring_item(), 1'b0, nothing);
            end
            // Hold the sender until every response of this pass is back
            req_if.valid <= 1'b0;
            while (due_rsp_q.size() != 0) @(posedge i_clk);
        end

        // Catch any stray response beat
        repeat (RING_ENTRIES + 6) @(posedge i_clk);
        if (mismatches == 0 && due_rsp_q.size() == 0) begin
            $display("[write_record_ring_offset_lookup] OK");
        end else begin
            $display("[write_record_ring_offset_lookup] ERROR");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : run_limit
        #(CLK_PERIOD * 1_000_000);
        $display("[write_record_ring_offset_lookup] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/wrol_pkg.sv
rtl/wrol_chan_if.sv
rtl/wrol_cell.sv
rtl/write_record_ring_offset_lookup.sv
tb/sv/write_record_ring_offset_lookup_tb.sv
